>>> src/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg
// shared types and constants of the message framer with checksum
// ----------------------------------------------------------------------------
package mfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 16;

  // opcode values
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // command queue between front and back
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // header byte order after the message id
  localparam logic [1:0] HDR_SENDER = 2'd0;
  localparam logic [1:0] HDR_ACK    = 2'd1;
  localparam logic [1:0] HDR_PEER   = 2'd2;
  localparam logic [1:0] HDR_LEN    = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [ByteW-1:0] msg_id;
    logic [ByteW-1:0] sender_id;
    logic             ack_flag;
    logic [ByteW-1:0] peer_number;
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             frame_last;
  } out_item_t;

  // classified word handed from front to back
  typedef struct packed {
    logic             is_start;
    logic             last_data;   // data word that completes the declared payload
    logic [ByteW-1:0] msg_id;
    logic [ByteW-1:0] sender_id;
    logic             ack_flag;
    logic [ByteW-1:0] peer_number;
    logic [ByteW-1:0] sat_length;  // length already saturated
    logic [ByteW-1:0] data_byte;
  } cmd_t;

endpackage

>>> src/mfc_front.sv
// ----------------------------------------------------------------------------
// mfc_front
// accepts input words, tracks the open frame and classifies each word
// ----------------------------------------------------------------------------
module mfc_front #(
  parameter int unsigned PAYLOAD_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  mfc_pkg::in_item_t item_i,
  output logic              cmd_push_o,
  output mfc_pkg::cmd_t     cmd_o
);
  import mfc_pkg::*;

  localparam int unsigned PosW = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [ByteW-1:0] MaxLen = ByteW'(PAYLOAD_BYTES);

  logic            open_q, open_d;
  logic [PosW-1:0] decl_q, decl_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] pos_inc;
  logic [ByteW-1:0] sat_len;
  logic            is_start;

  assign is_start = (item_i.opcode == OP_START);
  assign sat_len  = (item_i.payload_length > MaxLen) ? MaxLen : item_i.payload_length;
  assign pos_inc  = pos_q + PosW'(1);

  always_comb begin
    open_d     = open_q;
    decl_d     = decl_q;
    pos_d      = pos_q;
    cmd_push_o = 1'b0;
    if (accept_i) begin
      if (is_start) begin
        cmd_push_o = 1'b1;
        decl_d     = PosW'(sat_len);
        pos_d      = '0;
        open_d     = (sat_len != '0);
      end else if (open_q) begin
        cmd_push_o = 1'b1;
        pos_d      = pos_inc;
        if (pos_inc >= decl_q) begin
          open_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    cmd_o.is_start    = is_start;
    cmd_o.last_data   = (pos_inc >= decl_q);
    cmd_o.msg_id      = item_i.msg_id;
    cmd_o.sender_id   = item_i.sender_id;
    cmd_o.ack_flag    = item_i.ack_flag;
    cmd_o.peer_number = item_i.peer_number;
    cmd_o.sat_length  = sat_len;
    cmd_o.data_byte   = item_i.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      decl_q <= '0;
      pos_q  <= '0;
    end else begin
      open_q <= open_d;
      decl_q <= decl_d;
      pos_q  <= pos_d;
    end
  end

endmodule

>>> src/mfc_cmd_queue.sv
// ----------------------------------------------------------------------------
// mfc_cmd_queue
// short register queue of classified words between front and back
// ----------------------------------------------------------------------------
module mfc_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mfc_pkg::cmd_t data_o,
  output logic          empty_o
);
  import mfc_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CmdCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CmdCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CmdPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CmdPtrW'(1);
      end
    end
  end

endmodule

>>> src/mfc_back.sv
// ----------------------------------------------------------------------------
// mfc_back
// emits header, payload, padding and checksum bytes into the output register
// ----------------------------------------------------------------------------
module mfc_back #(
  parameter int unsigned PAYLOAD_BYTES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfc_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  output mfc_pkg::out_item_t item_o,
  output logic               empty,
  input  logic               pop
);
  import mfc_pkg::*;

  localparam int unsigned PosW = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [PosW-1:0] LastPos = PosW'(PAYLOAD_BYTES);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HDR  = 5'b00010,
    ST_PAD  = 5'b00100,
    ST_CKLO = 5'b01000,
    ST_CKHI = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       hdr_idx_q, hdr_idx_d;
  cmd_t             hdr_q, hdr_d;
  logic [PosW-1:0]  pos_q, pos_d, pos_inc;
  logic [ByteW-1:0] pending_q, pending_d;
  logic [SumW-1:0]  sum_q, sum_d, sum_inv;
  logic [SumW:0]    sum_raw;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_ready;
  logic             emit, pay_en;
  logic [ByteW-1:0] pay_byte;

  assign out_ready = !out_valid_q || pop;
  assign pos_inc   = pos_q + PosW'(1);
  assign sum_inv   = ~sum_q;

  always_comb begin
    state_d    = state_q;
    hdr_idx_d  = hdr_idx_q;
    hdr_d      = hdr_q;
    pos_d      = pos_q;
    pending_d  = pending_q;
    sum_d      = sum_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    pay_en     = 1'b0;
    pay_byte   = cmd_i.data_byte;
    out_d      = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (out_ready && !cmd_empty_i) begin
          cmd_pop_o  = 1'b1;
          emit       = 1'b1;
          if (cmd_i.is_start) begin
            out_d     = '{frame_byte: cmd_i.msg_id, frame_last: 1'b0};
            hdr_d     = cmd_i;
            hdr_idx_d = HDR_SENDER;
            pos_d     = '0;
            pending_d = '0;
            sum_d     = '0;
            state_d   = ST_HDR;
          end else begin
            out_d  = '{frame_byte: cmd_i.data_byte, frame_last: 1'b0};
            pay_en = 1'b1;
            if (cmd_i.last_data) begin
              state_d = (pos_inc >= LastPos) ? ST_CKLO : ST_PAD;
            end
          end
        end
      end
      ST_HDR: begin
        if (out_ready) begin
          emit      = 1'b1;
          hdr_idx_d = hdr_idx_q + 2'd1;
          out_d.frame_last = 1'b0;
          case (hdr_idx_q)
            HDR_SENDER: out_d.frame_byte = hdr_q.sender_id;
            HDR_ACK:    out_d.frame_byte = {{(ByteW-1){1'b0}}, hdr_q.ack_flag};
            HDR_PEER:   out_d.frame_byte = hdr_q.peer_number;
            default:    out_d.frame_byte = hdr_q.sat_length;
          endcase
          if (hdr_idx_q == HDR_LEN) begin
            state_d = (hdr_q.sat_length == '0) ? ST_PAD : ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        if (out_ready) begin
          emit     = 1'b1;
          pay_en   = 1'b1;
          pay_byte = '0;
          out_d    = '{frame_byte: '0, frame_last: 1'b0};
          if (pos_inc >= LastPos) begin
            state_d = ST_CKLO;
          end
        end
      end
      ST_CKLO: begin
        if (out_ready) begin
          emit    = 1'b1;
          out_d   = '{frame_byte: sum_inv[ByteW-1:0], frame_last: 1'b0};
          state_d = ST_CKHI;
        end
      end
      ST_CKHI: begin
        if (out_ready) begin
          emit    = 1'b1;
          out_d   = '{frame_byte: sum_inv[SumW-1:ByteW], frame_last: 1'b1};
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // payload byte: even position waits, odd position closes a word
    sum_raw = {1'b0, sum_q} + {1'b0, pay_byte, pending_q};
    if (pay_en) begin
      pos_d = pos_inc;
      if (!pos_q[0]) begin
        pending_d = pay_byte;
      end else if (sum_raw[SumW]) begin
        sum_d = sum_raw[SumW-1:0] + SumW'(1);
      end else begin
        sum_d = sum_raw[SumW-1:0];
      end
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign item_o = out_q;
  assign empty  = !out_valid_q;

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hdr_idx_q   <= '0;
      pos_q       <= '0;
      pending_q   <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_idx_q   <= hdr_idx_d;
      pos_q       <= pos_d;
      pending_q   <= pending_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/message_framer_with_checksum.sv
// ----------------------------------------------------------------------------
// message_framer_with_checksum
// builds fixed-size frames with a 16-bit ones' complement checksum
// ----------------------------------------------------------------------------
// A start word opens a frame and produces five header bytes (message id,
// sender id, ack flag, peer number, saturated length); each data word then
// produces one payload byte. Once the declared length is reached, zero
// padding fills the payload up to PAYLOAD_BYTES and the inverted checksum
// follows, low byte first, frame_last set on the high byte. A data word that
// adds a single byte streams at one word per cycle while the output is
// popped; a start word holds the output for its five header bytes (also all
// padding and both checksum bytes when its length is zero), and the closing
// data word for its own byte, the padding bytes and both checksum bytes. The
// back end's byte sequencer sets that cost; a four-entry word queue lets the
// input keep accepting meanwhile, and full rises only once it fills. Data
// words outside an open frame are taken and dropped. A start word inside an
// open frame abandons it without padding or checksum.
// ----------------------------------------------------------------------------
module message_framer_with_checksum #(
  parameter int unsigned PAYLOAD_BYTES = 32  // 2 to 57
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input word queue side
  input  logic               push,
  output logic               full,
  input  mfc_pkg::in_item_t  in_item_i,
  // result byte queue side
  output logic               empty,
  input  logic               pop,
  output mfc_pkg::out_item_t out_item_o
);
  import mfc_pkg::*;

  logic accept;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  cmd_t cmd_in, cmd_out;

  // a word is taken whenever the queue has room
  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  // front: frame tracking, drops stray data words
  mfc_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue
  mfc_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // back: byte sequencer, checksum and output register
  mfc_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .item_o      (out_item_o),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
